>>> hw/rtl/icob_pkg.sv
// shared constants and types of the interpolated cosine oscillator bank
package icob_pkg;

    localparam int MAX_OSC_DEF     = 16;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ACTIVE_W = 5;
    localparam int RATE_W   = 32;
    localparam int PHASE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int FREQ_W   = 24;
    localparam int CFG_W    = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;
    localparam logic [RATE_W-1:0]   RATE_RST   = 32'd183251938;

    // register indexes
    localparam logic CFG_ACTIVE_COUNT  = 1'b0;
    localparam logic CFG_INV_HALF_RATE = 1'b1;

    // item kinds
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_FREQ = 1'b1;

    typedef struct packed {
        logic shift;
        logic adv;
        logic wr;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/icob_cell.sv
// one oscillator cell: phase and increment, passed to the neighbor on shift
module icob_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  icob_pkg::cell_ctrl_t            ctrl,
    input  logic [icob_pkg::PHASE_W-1:0]    wr_inc,
    input  logic [icob_pkg::PHASE_W-1:0]    phase_in,
    input  logic [icob_pkg::PHASE_W-1:0]    inc_in,
    output logic [icob_pkg::PHASE_W-1:0]    phase_q,
    output logic [icob_pkg::PHASE_W-1:0]    phase_out,
    output logic [icob_pkg::PHASE_W-1:0]    inc_out
);

    logic [icob_pkg::PHASE_W-1:0] phase_reg;
    logic [icob_pkg::PHASE_W-1:0] inc_reg;

    assign phase_q   = phase_reg;
    assign inc_out   = inc_reg;
    // phase wraps modulo one full turn either way
    assign phase_out = ctrl.adv ? phase_reg + inc_reg : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            inc_reg   <= '0;
        end else if (ctrl.shift) begin
            phase_reg <= phase_in;
            inc_reg   <= inc_in;
        end else if (ctrl.wr) begin
            inc_reg <= wr_inc;
        end
    end

endmodule

>>> hw/rtl/icob_cos_rom.sv
// cosine table built at elaboration, two registered reads at k and k+1
module icob_cos_rom #(
    parameter int TABLE_BITS  = icob_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = icob_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic [TABLE_BITS-1:0]         addr,
    output logic signed [SAMPLE_BITS-1:0] cur,
    output logic signed [SAMPLE_BITS-1:0] nxt
);

    localparam int TBL_LEN   = (1 << TABLE_BITS) + 1;
    localparam int FRAC_BITS = 32 - TABLE_BITS;
    localparam longint AMP   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

    typedef logic signed [SAMPLE_BITS-1:0] tbl_t [TBL_LEN];

    function automatic tbl_t build_table();
        tbl_t        t;
        logic [63:0] p;
        logic [63:0] oct;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        logic        use_sin;
        logic        neg;
        int          k;
        int          j;
        for (k = 0; k < TBL_LEN; k++) begin
            p   = (64'(k) << FRAC_BITS) & 64'hFFFF_FFFF;
            oct = p >> 29;
            r   = p & 64'h1FFF_FFFF;
            if (oct[0])
                r = 64'h2000_0000 - r;
            x       = (r * 64'd3373259426) >> 31;
            use_sin = (oct == 1) || (oct == 2) || (oct == 5) || (oct == 6);
            neg     = (oct >= 2) && (oct <= 5);
            x2      = (x * x) >> 30;
            term    = use_sin ? x : (64'd1 << 30);
            sum     = term;
            for (j = 0; j < 7; j++) begin
                term = (term * x2) >> 30;
                if (use_sin) begin
                    unique case (j)
                        0: term = term / 6;
                        1: term = term / 20;
                        2: term = term / 42;
                        3: term = term / 72;
                        4: term = term / 110;
                        5: term = term / 156;
                        default: term = term / 210;
                    endcase
                end else begin
                    unique case (j)
                        0: term = term / 2;
                        1: term = term / 12;
                        2: term = term / 30;
                        3: term = term / 56;
                        4: term = term / 90;
                        5: term = term / 132;
                        default: term = term / 182;
                    endcase
                end
                if (j % 2 == 1)
                    sum = sum + term;
                else
                    sum = sum - term;
            end
            scaled = (sum * 64'(AMP) + (64'd1 << 29)) >> 30;
            t[k]   = neg ? -SAMPLE_BITS'(scaled) : SAMPLE_BITS'(scaled);
        end
        return t;
    endfunction

    localparam tbl_t TBL = build_table();

    logic [TABLE_BITS:0] addr_hi;
    assign addr_hi = {1'b0, addr} + 1'b1;

    always_ff @(posedge aclk) begin
        cur <= TBL[{1'b0, addr}];
        nxt <= TBL[addr_hi];
    end

endmodule

>>> hw/rtl/icob_divider.sv
// signed by unsigned restoring divider, one quotient bit per cycle
module icob_divider #(
    parameter int W  = 21,
    parameter int DW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic [DW-1:0]       divisor,
    output logic                done,
    output logic signed [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [W-1:0]  quo_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    assign done     = done_reg;
    // truncation toward zero: divide magnitudes, restore the sign
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[W-1];
            quo_reg <= dividend[W-1] ? W'(-dividend) : W'(dividend);
            rem_reg <= '0;
            cnt_reg <= CW'(W);
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/interpolated_cosine_oscillator_bank_unit.sv
// top level: oscillator cell ring, cosine table, interpolation pipeline, averaging divider
// set-frequency item: input ready again after the FMUL and FWR states, no result
// tick item: ring rotation (one oscillator a cycle), pipeline drain, ACC_W-bit divider,
//   output state (result and input ready together at its end, later while a previous
//   result is stalled); one item in work at a time
// synchronous active-low reset clears phases, increments, state and valids, loads config defaults; table is constant
module interpolated_cosine_oscillator_bank_unit #(
    parameter int MAX_OSC     = icob_pkg::MAX_OSC_DEF,
    parameter int TABLE_BITS  = icob_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = icob_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,  // osc_index, freq_hz, zero pad
    input  logic [0:0]                            s_tuser,  // opcode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // sample, zero pad
    input  logic                                  cfg_we,
    input  logic [0:0]                            cfg_index,
    input  logic [icob_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int OUT_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC_BITS = 32 - TABLE_BITS;
    localparam int NW        = $clog2(MAX_OSC + 1);
    localparam int ACC_W     = SAMPLE_BITS + $clog2(MAX_OSC) + 1;
    localparam int PW        = icob_pkg::PHASE_W;
    localparam int PROD_W    = icob_pkg::FREQ_W + icob_pkg::RATE_W;
    localparam int MUL_W     = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FMUL  = 3'd1;
    localparam logic [2:0] ST_FWR   = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [icob_pkg::ACTIVE_W-1:0] active_count_reg;
    logic [icob_pkg::RATE_W-1:0]   inv_half_rate_reg;

    logic [icob_pkg::INDEX_W-1:0]  osc_idx_reg;
    logic [icob_pkg::FREQ_W-1:0]   freq_reg;
    logic [PROD_W-1:0]             fprod_reg;
    logic                          fneg_reg;
    logic [icob_pkg::FREQ_W-1:0]   fmag;
    logic [PROD_W:0]               fround;
    logic [PROD_W-17:0]            fq;
    logic [PW-1:0]                 fq_clamp;
    logic [PW-1:0]                 new_inc;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] cnt_reg;
    logic          active;

    logic [PW-1:0] phase_q   [MAX_OSC];
    logic [PW-1:0] phase_out [MAX_OSC];
    logic [PW-1:0] inc_out   [MAX_OSC];

    logic                          v1_reg;
    logic                          v2_reg;
    logic [FRAC_BITS-1:0]          frac_reg;
    logic signed [SAMPLE_BITS-1:0] rom_cur;
    logic signed [SAMPLE_BITS-1:0] rom_nxt;
    logic signed [SAMPLE_BITS-1:0] cur2_reg;
    logic signed [MUL_W-1:0]       mul_reg;
    logic signed [MUL_W-1:0]       mul_next;
    logic signed [SAMPLE_BITS:0]   tdiff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    logic                    div_start;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_q;

    logic in_xfer;
    logic out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg  <= icob_pkg::ACTIVE_RST;
            inv_half_rate_reg <= icob_pkg::RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                icob_pkg::CFG_ACTIVE_COUNT:
                    active_count_reg <= cfg_wdata[icob_pkg::ACTIVE_W-1:0];
                icob_pkg::CFG_INV_HALF_RATE:
                    inv_half_rate_reg <= cfg_wdata[icob_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (active_count_reg == '0)
            n_eff = NW'(1);
        else if (int'(active_count_reg) > MAX_OSC)
            n_eff = NW'(MAX_OSC);
        else
            n_eff = NW'(active_count_reg);
    end

    // frequency to increment: magnitude times rate, round toward minus infinity, clamp
    assign fmag = freq_reg[icob_pkg::FREQ_W-1] ? -freq_reg : freq_reg;

    always_comb begin
        fround   = fneg_reg ? {1'b0, fprod_reg} + (PROD_W+1)'(17'h1FFFF)
                            : {1'b0, fprod_reg};
        fq       = fround[PROD_W:17];
        fq_clamp = (fq > (PROD_W-16)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : fq[PW-1:0];
        new_inc  = fneg_reg ? -fq_clamp : fq_clamp;
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            osc_idx_reg <= s_tdata[3:0];
            freq_reg    <= s_tdata[27:4];
        end
        if (state_reg == ST_FMUL) begin
            fprod_reg <= PROD_W'(fmag) * PROD_W'(inv_half_rate_reg);
            fneg_reg  <= freq_reg[icob_pkg::FREQ_W-1];
        end
    end

    // sequencer
    assign active    = cnt_reg < n_reg;
    assign div_start = (state_reg == ST_DRAIN) && !v1_reg && !v2_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer)
                    state_next = (s_tuser[0] == icob_pkg::OP_SET_FREQ) ? ST_FMUL : ST_TICK;
            end
            ST_FMUL:  state_next = ST_FWR;
            ST_FWR:   state_next = ST_IDLE;
            ST_TICK: begin
                if (cnt_reg == NW'(MAX_OSC - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (div_start)
                    state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            n_reg   <= n_eff;
            cnt_reg <= '0;
        end else if (state_reg == ST_TICK) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // ring of oscillator cells, head is cell 0
    for (genvar i = 0; i < MAX_OSC; i++) begin : g_cell
        icob_pkg::cell_ctrl_t ctrl;
        assign ctrl.shift = (state_reg == ST_TICK);
        assign ctrl.adv   = (i == 0) && active;
        assign ctrl.wr    = (state_reg == ST_FWR) && (int'(osc_idx_reg) == i);

        icob_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .wr_inc    (new_inc),
            .phase_in  (phase_out[(i + 1) % MAX_OSC]),
            .inc_in    (inc_out[(i + 1) % MAX_OSC]),
            .phase_q   (phase_q[i]),
            .phase_out (phase_out[i]),
            .inc_out   (inc_out[i])
        );
    end

    icob_cos_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .aclk (aclk),
        .addr (phase_q[0][PW-1:FRAC_BITS]),
        .cur  (rom_cur),
        .nxt  (rom_nxt)
    );

    // interpolation: table read, slope times fraction, floor and accumulate
    always_comb begin
        tdiff    = (SAMPLE_BITS+1)'(rom_nxt) - (SAMPLE_BITS+1)'(rom_cur);
        frac_s   = signed'({1'b0, frac_reg});
        mul_next = tdiff * frac_s;
        acc_next = acc_reg + ACC_W'(cur2_reg) + ACC_W'(mul_reg >>> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_TICK) && active;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg <= phase_q[0][FRAC_BITS-1:0];
        cur2_reg <= rom_cur;
        mul_reg  <= mul_next;
        if (in_xfer)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_next;
    end

    icob_divider #(
        .W  (ACC_W),
        .DW (NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free)
            m_tdata <= OUT_W'(div_q[SAMPLE_BITS-1:0]);
    end

endmodule

>>> hw/rtl/icob_checker.sv
// port-level checks of the oscillator bank, bound to the top level
module icob_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata_lo
);

    // result register empties on reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a pending result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata_lo))
        else $error("result dropped or changed while stalled");

    // one item at a time: busy after a transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a frequency write gives no result
    a_set_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result after a frequency write");

    // a new result appears only at the end of a tick, while input is closed
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a tick in work");

endmodule

bind interpolated_cosine_oscillator_bank_unit icob_checker u_icob_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata_lo (m_tdata[7:0])
);
